// ===== design/lwrprf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the LWR PRF combiner.
package lwrprf_pkg;

  // Field and state widths.
  localparam int unsigned ElemW      = 32;
  localparam int unsigned LogW       = 6;
  localparam int unsigned LpW        = 5;
  localparam int unsigned LenW       = 11;
  localparam int unsigned CntW       = 5;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned ShrW       = 4;
  localparam int unsigned MaxLength  = 1024;
  localparam int unsigned MaxShares  = 16;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_LOG_Q     = 3'd1,
    REG_LOG_Q1    = 3'd2,
    REG_LOG_P     = 3'd3,
    REG_VEC_LEN   = 3'd4,
    REG_SHARE_CNT = 3'd5
  } reg_idx_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic            threshold_mode;
    logic [LogW-1:0] log_q;
    logic [LogW-1:0] log_q1;
    logic [LpW-1:0]  log_p;
    logic [LenW-1:0] vector_length;
    logic [CntW-1:0] share_count;
  } cfg_t;

  // Reset values of the registers.
  localparam logic            RstMode     = 1'b1;
  localparam logic [LogW-1:0] RstLogQ     = 6'd32;
  localparam logic [LogW-1:0] RstLogQ1    = 6'd28;
  localparam logic [LpW-1:0]  RstLogP     = 5'd10;
  localparam logic [LenW-1:0] RstVecLen   = 11'd512;
  localparam logic [CntW-1:0] RstShareCnt = 5'd5;

  // Log values above the element width act as the element width.
  function automatic logic [LogW-1:0] cap_log(input logic [LogW-1:0] v);
    logic [LogW-1:0] res;
    res = (v > LogW'(ElemW)) ? LogW'(ElemW) : v;
    return res;
  endfunction

  // Mask of the low bits bits (bits is at most the element width).
  function automatic logic [ElemW-1:0] low_mask(input logic [LogW-1:0] bits);
    logic [ElemW:0] m;
    m = ({{ElemW{1'b0}}, 1'b1} << bits) - {{ElemW{1'b0}}, 1'b1};
    return m[ElemW-1:0];
  endfunction

  // Round-half-up from 2^from to 2^to; passes through if it does not shrink.
  function automatic logic [ElemW-1:0] round_down(input logic [ElemW-1:0] v,
                                                  input logic [LogW-1:0]  from_log,
                                                  input logic [LogW-1:0]  to_log);
    logic [LogW-1:0]  d;
    logic [ElemW-1:0] sh;
    logic [ElemW:0]   sum;
    logic [ElemW-1:0] res;
    d   = from_log - to_log;
    sh  = v >> (d - LogW'(1));
    sum = {1'b0, (sh >> 1)} + {{ElemW{1'b0}}, sh[0]};
    if (to_log >= from_log) begin
      res = v;
    end else begin
      res = sum[ElemW-1:0];
    end
    return res;
  endfunction

  // Zero length acts as one; long vectors are clipped.
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] v);
    logic [LenW-1:0] res;
    if (v == '0) begin
      res = LenW'(1);
    end else if (v > LenW'(MaxLength)) begin
      res = LenW'(MaxLength);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Zero share count acts as one; large counts are clipped.
  function automatic logic [CntW-1:0] eff_cnt(input logic [CntW-1:0] v);
    logic [CntW-1:0] res;
    if (v == '0) begin
      res = CntW'(1);
    end else if (v > CntW'(MaxShares)) begin
      res = CntW'(MaxShares);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== design/lwrprf_regs.sv =====
// APB-style configuration register file for the LWR PRF combiner.
module lwrprf_regs
  import lwrprf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o   = cfg_q;

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_mode <= RstMode;
      cfg_q.log_q          <= RstLogQ;
      cfg_q.log_q1         <= RstLogQ1;
      cfg_q.log_p          <= RstLogP;
      cfg_q.vector_length  <= RstVecLen;
      cfg_q.share_count    <= RstShareCnt;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:      cfg_q.threshold_mode <= pwdata[0];
        REG_LOG_Q:     cfg_q.log_q          <= pwdata[LogW-1:0];
        REG_LOG_Q1:    cfg_q.log_q1         <= pwdata[LogW-1:0];
        REG_LOG_P:     cfg_q.log_p          <= pwdata[LpW-1:0];
        REG_VEC_LEN:   cfg_q.vector_length  <= pwdata[LenW-1:0];
        REG_SHARE_CNT: cfg_q.share_count    <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_MODE:      prdata = DataW'(cfg_q.threshold_mode);
      REG_LOG_Q:     prdata = DataW'(cfg_q.log_q);
      REG_LOG_Q1:    prdata = DataW'(cfg_q.log_q1);
      REG_LOG_P:     prdata = DataW'(cfg_q.log_p);
      REG_VEC_LEN:   prdata = DataW'(cfg_q.vector_length);
      REG_SHARE_CNT: prdata = DataW'(cfg_q.share_count);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/lwr_threshold_prf_combine_top.sv =====
// Top level of the LWR PRF evaluator with threshold share combining.
//
// Each accepted item is one pair of vector and key-share elements. The block
// takes one item per clock cycle for as long as the output side keeps up; a
// five-register pipeline (input, product, vector result, combined value,
// output) carries the work, with the 32x32 multiplier alone in its own stage
// and the modulo-q accumulation done in the stage after it. The result of a
// vector (direct mode) or last share (threshold mode) leaves via the vector
// result, combined value and output registers. Every stage can fill while
// the output register waits, so input stalls only when all stages hold work.
module lwr_threshold_prf_combine_top
  import lwrprf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ElemW-1:0] x_element_i,
  input  logic [ElemW-1:0] share_element_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ElemW-1:0] prf_value_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  lwrprf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline registers.
  logic             in_v_q, prod_v_q, vec_v_q, fin_v_q, out_v_q;
  logic [ElemW-1:0] x_q, s_q, prod_q, vec_r_q, fin_val_q, out_q;
  logic [LogW-1:0]  fin_log_q;

  // Running state.
  logic [ElemW-1:0] acc_q, comb_q;
  logic [IdxW-1:0]  elem_idx_q;
  logic [ShrW-1:0]  share_idx_q;

  // Handshake chain: a stage moves when the next one is empty or moving.
  logic out_rdy, fin_rdy, vec_rdy, prod_rdy, in_rdy;
  logic prod_load, acc_fire, vec_fire, fin_fire;

  assign out_rdy   = !out_v_q | !out_stall_i;
  assign fin_rdy   = !fin_v_q | out_rdy;
  assign vec_rdy   = !vec_v_q | fin_rdy;
  assign prod_rdy  = !prod_v_q | vec_rdy;
  assign in_rdy    = !in_v_q | prod_rdy;
  assign in_stall_o = !in_rdy;

  assign prod_load = in_v_q & prod_rdy;
  assign acc_fire  = prod_v_q & vec_rdy;
  assign vec_fire  = vec_v_q & fin_rdy;
  assign fin_fire  = fin_v_q & out_rdy;

  // Effective configuration.
  logic [LogW-1:0] lq, lq1;
  logic [LenW-1:0] len;
  logic [CntW-1:0] cnt;

  assign lq  = cap_log(cfg.log_q);
  assign lq1 = cap_log(cfg.log_q1);
  assign len = eff_len(cfg.vector_length);
  assign cnt = eff_cnt(cfg.share_count);

  // Product stage: low word of the element product.
  logic [ElemW-1:0] prod_d;
  assign prod_d = x_q * s_q;

  // Accumulate stage: inner product modulo q and end-of-vector test.
  logic [ElemW-1:0] acc_d;
  logic             vec_end;
  assign acc_d   = (acc_q + prod_q) & low_mask(lq);
  assign vec_end = ({1'b0, elem_idx_q} + LenW'(1)) >= len;

  // Combine stage: round the share to q1 and add or subtract it.
  logic [ElemW-1:0] r_q1, comb_d, fin_val_d;
  logic             last_share, fin_emit;
  logic [LogW-1:0]  fin_log_d;

  assign r_q1       = round_down(vec_r_q, lq, lq1);
  assign comb_d     = ((share_idx_q == '0) ? (comb_q + r_q1) : (comb_q - r_q1))
                      & low_mask(lq1);
  assign last_share = ({1'b0, share_idx_q} + CntW'(1)) >= cnt;
  assign fin_emit   = !cfg.threshold_mode | last_share;
  assign fin_val_d  = cfg.threshold_mode ? comb_d : vec_r_q;
  assign fin_log_d  = cfg.threshold_mode ? lq1 : lq;

  // Output stage: final rounding to p.
  logic [ElemW-1:0] out_d;
  assign out_d = round_down(fin_val_q, fin_log_q, {1'b0, cfg.log_p});

  // Stage valid bits and running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      vec_v_q     <= 1'b0;
      fin_v_q     <= 1'b0;
      out_v_q     <= 1'b0;
      acc_q       <= '0;
      comb_q      <= '0;
      elem_idx_q  <= '0;
      share_idx_q <= '0;
    end else begin
      if (in_rdy)   in_v_q   <= in_valid_i;
      if (prod_rdy) prod_v_q <= in_v_q;
      if (vec_rdy)  vec_v_q  <= acc_fire & vec_end;
      if (fin_rdy)  fin_v_q  <= vec_fire & fin_emit;
      if (out_rdy)  out_v_q  <= fin_fire;

      if (acc_fire) begin
        if (vec_end) begin
          acc_q      <= '0;
          elem_idx_q <= '0;
        end else begin
          acc_q      <= acc_d;
          elem_idx_q <= elem_idx_q + IdxW'(1);
        end
      end

      if (vec_fire && cfg.threshold_mode) begin
        if (last_share) begin
          comb_q      <= '0;
          share_idx_q <= '0;
        end else begin
          comb_q      <= comb_d;
          share_idx_q <= share_idx_q + ShrW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_rdy) begin
      x_q <= x_element_i;
      s_q <= share_element_i;
    end
    if (prod_load) prod_q <= prod_d;
    if (acc_fire && vec_end) vec_r_q <= acc_d;
    if (vec_fire) begin
      fin_val_q <= fin_val_d;
      fin_log_q <= fin_log_d;
    end
    if (fin_fire) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign prf_value_o = out_q;

`ifndef ASSERT_OFF
  // Input is held back only while the input register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_v_q)
    else $error("input stalled with an empty input register");

  // A finished vector restarts the element count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (acc_fire && vec_end) |=> (elem_idx_q == '0 && acc_q == '0))
    else $error("element index or accumulator not cleared at vector end");

  // The share index moves only when a vector result is combined.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !vec_fire |=> $stable(share_idx_q))
    else $error("share index changed without a vector result");

  // A pending final value is not dropped while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fin_v_q && !out_rdy) |=> (fin_v_q && $stable(fin_val_q)))
    else $error("final value lost while output was stalled");
`endif

endmodule
